### rtl/pnnc_pkg.sv
package pnnc_pkg;

  localparam int WFRAC = 12;
  localparam int LEARN_SHIFT = 20;
  localparam logic [3:0] LAST_STEP = 4'd14;

  typedef enum logic [2:0] {
    REG_SET_W   = 3'd0,
    REG_MEAS_W  = 3'd1,
    REG_INIT_OW = 3'd2,
    REG_INIT_LM = 3'd3,
    REG_LRATE   = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    MS_SP0, MS_MS0, MS_SP1, MS_MS1, MS_SP2, MS_MS2,
    MS_OW0, MS_OW1, MS_OW2, MS_LR, MS_LE0, MS_LE1, MS_LE2
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic       start;
    mul_sel_e   mul_sel;
    acc_op_e    acc_op;
    logic       cap_p;
    logic       cap_i;
    logic       cap_d;
    logic       cap_drv;
    logic       cap_le;
    logic [2:0] upd_w;
    logic       upd_lim;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
    logic signed [15:0] r;
    if (x > 32'sd32767) r = 16'sh7fff;
    else if (x < -32'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) r = x[32] ? 32'sh80000000 : 32'sh7fffffff;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [16:0] clamp_abs(input logic signed [32:0] x,
                                                   input logic signed [15:0] lim);
    logic        [16:0] t;
    logic signed [32:0] tp;
    logic signed [32:0] tn;
    logic signed [16:0] r;
    t  = lim[15] ? (17'd0 - {lim[15], lim}) : {1'b0, lim};
    tp = $signed({16'd0, t});
    tn = 33'sd0 - tp;
    if (x > tp) r = tp[16:0];
    else if (x < tn) r = tn[16:0];
    else r = x[16:0];
    return r;
  endfunction

endpackage

### rtl/pnnc_ctrl.sv
module pnnc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pnnc_pkg::status_t status_i,
  output pnnc_pkg::cmd_t    cmd_o
);

  pnnc_pkg::state_e state_q, state_d;
  logic [3:0]       step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pnnc_pkg::ST_IDLE;
      step_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      pnnc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pnnc_pkg::ST_RUN;
          step_d  = 4'd0;
        end
      end
      pnnc_pkg::ST_RUN: begin
        if (step_q == pnnc_pkg::LAST_STEP) begin
          if (!status_i.out_busy) state_d = pnnc_pkg::ST_IDLE;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      default: state_d = pnnc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = pnnc_pkg::MS_SP0;
    cmd_o.acc_op  = pnnc_pkg::ACC_HOLD;
    in_stall_o    = (state_q != pnnc_pkg::ST_IDLE);
    cmd_o.start   = (state_q == pnnc_pkg::ST_IDLE) && in_valid_i;
    if (state_q == pnnc_pkg::ST_RUN) begin
      unique case (step_q)
        4'd0: cmd_o.mul_sel = pnnc_pkg::MS_SP0;
        4'd1: begin
          cmd_o.mul_sel = pnnc_pkg::MS_MS0;
          cmd_o.acc_op  = pnnc_pkg::ACC_LOAD;
        end
        4'd2: begin
          cmd_o.mul_sel = pnnc_pkg::MS_SP1;
          cmd_o.acc_op  = pnnc_pkg::ACC_ADD;
        end
        4'd3: begin
          cmd_o.mul_sel = pnnc_pkg::MS_MS1;
          cmd_o.acc_op  = pnnc_pkg::ACC_LOAD;
          cmd_o.cap_p   = 1'b1;
        end
        4'd4: begin
          cmd_o.mul_sel = pnnc_pkg::MS_SP2;
          cmd_o.acc_op  = pnnc_pkg::ACC_ADD;
        end
        4'd5: begin
          cmd_o.mul_sel = pnnc_pkg::MS_MS2;
          cmd_o.acc_op  = pnnc_pkg::ACC_LOAD;
          cmd_o.cap_i   = 1'b1;
        end
        4'd6: begin
          cmd_o.mul_sel = pnnc_pkg::MS_OW0;
          cmd_o.acc_op  = pnnc_pkg::ACC_ADD;
        end
        4'd7: begin
          cmd_o.mul_sel = pnnc_pkg::MS_OW1;
          cmd_o.acc_op  = pnnc_pkg::ACC_LOAD;
          cmd_o.cap_d   = 1'b1;
        end
        4'd8: begin
          cmd_o.mul_sel = pnnc_pkg::MS_OW2;
          cmd_o.acc_op  = pnnc_pkg::ACC_ADD;
        end
        4'd9: begin
          cmd_o.mul_sel = pnnc_pkg::MS_LR;
          cmd_o.acc_op  = pnnc_pkg::ACC_ADD;
        end
        4'd10: begin
          cmd_o.mul_sel = pnnc_pkg::MS_LE0;
          cmd_o.cap_drv = 1'b1;
          cmd_o.cap_le  = 1'b1;
        end
        4'd11: begin
          cmd_o.mul_sel = pnnc_pkg::MS_LE1;
          cmd_o.upd_w   = 3'b001;
        end
        4'd12: begin
          cmd_o.mul_sel = pnnc_pkg::MS_LE2;
          cmd_o.upd_w   = 3'b010;
        end
        4'd13: begin
          cmd_o.upd_w   = 3'b100;
          cmd_o.upd_lim = 1'b1;
        end
        4'd14: cmd_o.load_out = !status_i.out_busy;
        default: cmd_o.acc_op = pnnc_pkg::ACC_HOLD;
      endcase
    end
  end

endmodule

### rtl/pnnc_dp.sv
module pnnc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pnnc_pkg::cmd_t     cmd_i,
  output pnnc_pkg::status_t  status_o,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] measurement_i,
  input  logic               adapt_i,
  input  logic               reload_i,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] drive_o,
  output logic               saturated_o
);

  logic [47:0]        set_w_q, meas_w_q, init_ow_q, init_lm_q;
  logic [15:0]        lrate_q;
  logic signed [15:0] sp_q, ms_q;
  logic               adapt_q;
  logic signed [15:0] ow_q [3];
  logic signed [15:0] lim_q [3];
  logic signed [16:0] neu_q [3];
  logic signed [31:0] int_q, prev_q;
  logic signed [50:0] p_q;
  logic signed [35:0] acc_q, acc_d;
  logic signed [33:0] le_q;
  logic signed [15:0] drive_q;
  logic               hit_q;
  logic               out_valid_q;
  logic signed [15:0] drive_out_q;
  logic               sat_out_q;

  logic signed [33:0] a_op;
  logic signed [16:0] b_op;
  logic signed [50:0] prod;
  logic signed [16:0] err;
  logic signed [35:0] acc_shift;
  logic signed [31:0] sum32;
  logic signed [32:0] int_sum, d_diff;
  logic signed [31:0] int_new, d_new;
  logic signed [15:0] drv;
  logic signed [50:0] delta_full;
  logic signed [31:0] delta32;

  assign err        = {sp_q[15], sp_q} - {ms_q[15], ms_q};
  assign acc_shift  = acc_q >>> pnnc_pkg::WFRAC;
  assign sum32      = acc_shift[31:0];
  assign int_sum    = {int_q[31], int_q} + {sum32[31], sum32};
  assign int_new    = pnnc_pkg::sat32(int_sum);
  assign d_diff     = {sum32[31], sum32} - {prev_q[31], prev_q};
  assign d_new      = pnnc_pkg::sat32(d_diff);
  assign drv        = pnnc_pkg::sat16(sum32);
  assign delta_full = p_q >>> pnnc_pkg::LEARN_SHIFT;
  assign delta32    = delta_full[31:0];

  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd_i.mul_sel)
      pnnc_pkg::MS_SP0: begin
        a_op = 34'($signed(set_w_q[15:0]));
        b_op = 17'(sp_q);
      end
      pnnc_pkg::MS_MS0: begin
        a_op = 34'($signed(meas_w_q[15:0]));
        b_op = 17'(ms_q);
      end
      pnnc_pkg::MS_SP1: begin
        a_op = 34'($signed(set_w_q[31:16]));
        b_op = 17'(sp_q);
      end
      pnnc_pkg::MS_MS1: begin
        a_op = 34'($signed(meas_w_q[31:16]));
        b_op = 17'(ms_q);
      end
      pnnc_pkg::MS_SP2: begin
        a_op = 34'($signed(set_w_q[47:32]));
        b_op = 17'(sp_q);
      end
      pnnc_pkg::MS_MS2: begin
        a_op = 34'($signed(meas_w_q[47:32]));
        b_op = 17'(ms_q);
      end
      pnnc_pkg::MS_OW0: begin
        a_op = 34'(ow_q[0]);
        b_op = neu_q[0];
      end
      pnnc_pkg::MS_OW1: begin
        a_op = 34'(ow_q[1]);
        b_op = neu_q[1];
      end
      pnnc_pkg::MS_OW2: begin
        a_op = 34'(ow_q[2]);
        b_op = neu_q[2];
      end
      pnnc_pkg::MS_LR: begin
        a_op = 34'(err);
        b_op = $signed({1'b0, lrate_q});
      end
      pnnc_pkg::MS_LE0: begin
        a_op = p_q[33:0];
        b_op = neu_q[0];
      end
      pnnc_pkg::MS_LE1: begin
        a_op = le_q;
        b_op = neu_q[1];
      end
      pnnc_pkg::MS_LE2: begin
        a_op = le_q;
        b_op = neu_q[2];
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod = a_op * b_op;

  always_comb begin
    case (cmd_i.acc_op)
      pnnc_pkg::ACC_LOAD: acc_d = p_q[35:0];
      pnnc_pkg::ACC_ADD:  acc_d = acc_q + p_q[35:0];
      default:            acc_d = acc_q;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_w_q   <= '0;
      meas_w_q  <= '0;
      init_ow_q <= '0;
      init_lm_q <= '0;
      lrate_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pnnc_pkg::REG_SET_W:   set_w_q   <= cfg_data_i;
        pnnc_pkg::REG_MEAS_W:  meas_w_q  <= cfg_data_i;
        pnnc_pkg::REG_INIT_OW: init_ow_q <= cfg_data_i;
        pnnc_pkg::REG_INIT_LM: init_lm_q <= cfg_data_i;
        pnnc_pkg::REG_LRATE:   lrate_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    p_q   <= prod;
    acc_q <= acc_d;
    if (cmd_i.start) begin
      sp_q    <= setpoint_i;
      ms_q    <= measurement_i;
      adapt_q <= adapt_i;
    end
    if (cmd_i.cap_p) neu_q[0] <= pnnc_pkg::clamp_abs({sum32[31], sum32}, lim_q[0]);
    if (cmd_i.cap_i) neu_q[1] <= pnnc_pkg::clamp_abs({int_new[31], int_new}, lim_q[1]);
    if (cmd_i.cap_d) neu_q[2] <= pnnc_pkg::clamp_abs({d_new[31], d_new}, lim_q[2]);
    if (cmd_i.cap_le) le_q <= p_q[33:0];
    if (cmd_i.cap_drv) drive_q <= drv;
  end

  // adaptive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        ow_q[k]  <= '0;
        lim_q[k] <= '0;
      end
      int_q  <= '0;
      prev_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        hit_q <= 1'b0;
        if (reload_i) begin
          for (int k = 0; k < 3; k++) begin
            ow_q[k]  <= init_ow_q[16*k +: 16];
            lim_q[k] <= init_lm_q[16*k +: 16];
          end
          int_q <= '0;
        end
      end
      if (cmd_i.cap_i) begin
        int_q <= int_new;
        if (int_sum != {int_new[31], int_new}) hit_q <= 1'b1;
      end
      if (cmd_i.cap_d) prev_q <= sum32;
      if (cmd_i.cap_drv && ({{16{drv[15]}}, drv} != sum32)) hit_q <= 1'b1;
      if (adapt_q) begin
        for (int k = 0; k < 3; k++) begin
          if (cmd_i.upd_w[k]) ow_q[k] <= pnnc_pkg::sat16(32'(ow_q[k]) + delta32);
          if (cmd_i.upd_lim) lim_q[k] <= pnnc_pkg::sat16(32'(lim_q[k]) + 32'(err));
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      drive_out_q <= '0;
      sat_out_q   <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
      drive_out_q <= drive_q;
      sat_out_q   <= hit_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign drive_o           = drive_out_q;
  assign saturated_o       = sat_out_q;

endmodule

### rtl/pid_neural_net_controller.sv
// one step of a shared 34x17 multiplier per cycle through forward pass and
// weight learning; a waiting result stalls the last step
// a new item is taken only after the last one has finished
// reset: asynchronous active low; clears config, weights, limits, integrator,
// previous d sum and the handshake state
module pid_neural_net_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] measurement_i,
  input  logic               adapt_i,
  input  logic               reload_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] drive_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i
);

  pnnc_pkg::cmd_t    cmd;
  pnnc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  pnnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pnnc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .setpoint_i    (setpoint_i),
    .measurement_i (measurement_i),
    .adapt_i       (adapt_i),
    .reload_i      (reload_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drive_o       (drive_o),
    .saturated_o   (saturated_o)
  );

endmodule

### rtl/pnnc_checker.sv
module pnnc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] drive_o,
  input logic        saturated_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  // busy right after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input taken while item in flight");

  // a new result shows up only as the item finishes
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o && $past(in_stall_o))
    else $error("result without finished item");

endmodule

bind pid_neural_net_controller pnnc_checker u_pnnc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o),
  .saturated_o (saturated_o)
);

### verif/pid_neural_net_controller_tb.sv
`timescale 1ns / 1ps

module pid_neural_net_controller_tb;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               saturated;
  } drive_t;

  class drive_scoreboard;
    logic [47:0] set_w, meas_w, init_ow, init_lim;
    logic [15:0] lrate;
    longint      out_w[3];
    longint      lim[3];
    longint      integ;
    longint      prev_d;
    drive_t      pending[$];
    int          errors;

    function void clear();
      set_w = '0;
      meas_w = '0;
      init_ow = '0;
      init_lim = '0;
      lrate = '0;
      for (int i = 0; i < 3; i++) begin
        out_w[i] = 0;
        lim[i] = 0;
      end
      integ = 0;
      prev_d = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(pnnc_pkg::reg_idx_e idx, logic [47:0] data);
      case (idx)
        pnnc_pkg::REG_SET_W: set_w = data;
        pnnc_pkg::REG_MEAS_W: meas_w = data;
        pnnc_pkg::REG_INIT_OW: init_ow = data;
        pnnc_pkg::REG_INIT_LM: init_lim = data;
        pnnc_pkg::REG_LRATE: lrate = data[15:0];
        default: ;
      endcase
    endfunction

    function longint lane_of(logic [47:0] v, int i);
      logic signed [15:0] s;
      s = v[16*i +: 16];
      return longint'(s);
    endfunction

    function longint floor_shift(longint x, int s);
      return x >>> s;
    endfunction

    function longint limit_to(longint v, int bits, ref bit hit);
      longint mx, mn;
      mx = (longint'(1) <<< (bits - 1)) - 1;
      mn = -mx - 1;
      if (v > mx) begin
        hit = 1;
        return mx;
      end
      if (v < mn) begin
        hit = 1;
        return mn;
      end
      return v;
    endfunction

    function longint clamp_mag(longint x, longint l);
      longint t;
      t = (l < 0) ? -l : l;
      if (x > t) return t;
      if (x < -t) return -t;
      return x;
    endfunction

    function void note_input(logic signed [15:0] sp_in, logic signed [15:0] ms_in,
                             logic adapt, logic reload);
      longint sp, ms, sums[3], neu[3], acc, drv, err, delta;
      bit     hit, dummy;
      drive_t r;
      sp = longint'(sp_in);
      ms = longint'(ms_in);
      hit = 0;
      dummy = 0;
      if (reload) begin
        for (int i = 0; i < 3; i++) begin
          out_w[i] = lane_of(init_ow, i);
          lim[i] = lane_of(init_lim, i);
        end
        integ = 0;
      end
      for (int i = 0; i < 3; i++)
        sums[i] = floor_shift(lane_of(meas_w, i) * ms + lane_of(set_w, i) * sp,
                              pnnc_pkg::WFRAC);
      neu[0] = clamp_mag(sums[0], lim[0]);
      integ = limit_to(integ + sums[1], 32, hit);
      neu[1] = clamp_mag(integ, lim[1]);
      neu[2] = clamp_mag(limit_to(sums[2] - prev_d, 32, dummy), lim[2]);
      prev_d = limit_to(sums[2], 32, dummy);
      acc = 0;
      for (int i = 0; i < 3; i++) acc += out_w[i] * neu[i];
      drv = limit_to(floor_shift(acc, pnnc_pkg::WFRAC), 16, hit);
      if (adapt) begin
        err = sp - ms;
        for (int i = 0; i < 3; i++) begin
          delta = floor_shift(longint'(lrate) * err * neu[i], pnnc_pkg::LEARN_SHIFT);
          out_w[i] = limit_to(out_w[i] + delta, 16, dummy);
          lim[i] = limit_to(lim[i] + err, 16, dummy);
        end
      end
      r.drive = drv[15:0];
      r.saturated = hit;
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] drive, logic saturated);
      drive_t e;
      if (pending.size() == 0) begin
        $error("unexpected result drive=%0d saturated=%0b", drive, saturated);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (drive !== e.drive) begin
        $error("drive: expected %0d actual %0d", e.drive, drive);
        errors++;
      end
      if (saturated !== e.saturated) begin
        $error("saturated: expected %0b actual %0b", e.saturated, saturated);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o;
  logic signed [15:0] setpoint_i, measurement_i;
  logic               adapt_i, reload_i;
  logic               out_valid_o, out_stall_i;
  logic signed [15:0] drive_o;
  logic               saturated_o;
  logic               cfg_valid_i, cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [47:0]        cfg_data_i;

  int in_idle_pct, out_stall_pct;
  drive_scoreboard sb;

  pid_neural_net_controller dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(drive_o, saturated_o);
  end

  always @(negedge clk_i) begin
    if (out_stall_pct > 0) out_stall_i <= ($urandom_range(99) < out_stall_pct);
    else out_stall_i <= 1'b0;
  end

  // config only changes with nothing in flight
  task automatic write_cfg(pnnc_pkg::reg_idx_e idx, logic [47:0] data);
    while (sb.pending.size() != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send(logic signed [15:0] sp, logic signed [15:0] ms, logic ad, logic rl);
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    setpoint_i <= sp;
    measurement_i <= ms;
    adapt_i <= ad;
    reload_i <= rl;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(sp, ms, ad, rl);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand_pack();
    return {16'($urandom_range(65535)), 16'($urandom_range(65535)),
            16'($urandom_range(65535))};
  endfunction

  // weights kept small so sums stay in a useful range most of the time
  function automatic logic [15:0] small_w();
    logic signed [15:0] v;
    v = $signed(16'($urandom_range(4096))) - 16'sd2048;
    return v;
  endfunction

  task automatic random_cfg(int mode);
    if (mode == 0) begin
      write_cfg(pnnc_pkg::REG_SET_W, rand_pack());
      write_cfg(pnnc_pkg::REG_MEAS_W, rand_pack());
      write_cfg(pnnc_pkg::REG_INIT_OW, rand_pack());
      write_cfg(pnnc_pkg::REG_INIT_LM, rand_pack());
      write_cfg(pnnc_pkg::REG_LRATE, 48'($urandom_range(65535)));
    end else begin
      write_cfg(pnnc_pkg::REG_SET_W, {small_w(), small_w(), small_w()});
      write_cfg(pnnc_pkg::REG_MEAS_W, {small_w(), small_w(), small_w()});
      write_cfg(pnnc_pkg::REG_INIT_OW, {small_w(), small_w(), small_w()});
      write_cfg(pnnc_pkg::REG_INIT_LM, rand_pack());
      write_cfg(pnnc_pkg::REG_LRATE, 48'($urandom_range(4096)));
    end
  endtask

  task automatic random_items(int n);
    logic signed [15:0] sp, ms;
    for (int i = 0; i < n; i++) begin
      sp = 16'($urandom_range(65535));
      ms = 16'($urandom_range(65535));
      if ($urandom_range(3) != 0) begin
        sp = sp >>> 4;
        ms = sp - ($signed(16'($urandom_range(1023))) - 16'sd512);
      end
      send(sp, ms, 1'($urandom_range(1)), $urandom_range(15) == 0);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    in_idle_pct = 0;
    out_stall_pct = 0;
    rst_ni = 0;
    in_valid_i = 0;
    setpoint_i = '0;
    measurement_i = '0;
    adapt_i = 0;
    reload_i = 0;
    out_stall_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = pnnc_pkg::REG_SET_W;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: all-zero config first, then extremes
    send(16'sh7fff, 16'sh8000, 1, 0);
    write_cfg(pnnc_pkg::REG_SET_W, {16'sh7fff, 16'sh8000, 16'sh1000});
    write_cfg(pnnc_pkg::REG_MEAS_W, {16'sh8000, 16'sh7fff, 16'shf000});
    write_cfg(pnnc_pkg::REG_INIT_OW, {16'sh7fff, 16'sh8000, 16'sh7fff});
    write_cfg(pnnc_pkg::REG_INIT_LM, {16'sh8000, 16'sh0000, 16'sh7fff});
    write_cfg(pnnc_pkg::REG_LRATE, 48'h00000000ffff);
    send(16'sh7fff, 16'sh8000, 0, 1);
    send(16'sh8000, 16'sh7fff, 1, 0);
    repeat (6) send(16'sh7fff, 16'sh8000, 1, 0);
    send(16'sh0000, 16'sh0000, 1, 1);
    send(16'shffff, 16'sh0001, 0, 0);
    repeat (4) send(16'sh8000, 16'sh7fff, 0, 0);
    drain();
    write_cfg(pnnc_pkg::REG_INIT_LM, {16'sh8000, 16'sh8000, 16'sh8000});
    write_cfg(pnnc_pkg::REG_LRATE, 48'h0);
    send(16'sh0100, 16'sh0000, 1, 1);
    send(16'sh7fff, 16'sh7fff, 1, 0);
    send(16'sh5555, 16'shaaaa, 0, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 47; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 47; end
        default: begin in_idle_pct = 37; out_stall_pct = 37; end
      endcase
      random_cfg(ph % 2);
      send(16'sh0000, 16'sh0000, 0, 1);
      random_items(60);
      drain();
      random_cfg(1);
      send(16'($urandom_range(65535)), 16'($urandom_range(65535)), 1, 1);
      random_items(60);
      drain();
    end

    out_stall_pct = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
